// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Each macro takes a label, the clock, the active-low reset, the condition,
// the consequence and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lrg_pkg.sv =====
`timescale 1ns / 1ps

package lrg_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int LEVEL_W       = 32;
    localparam int ACTION_W      = 2;
    localparam int RAMP_W        = 16;
    localparam int GRAIN_W       = 16;
    localparam int APB_DATA_W    = 32;
    localparam int PADDR_W       = 3;

    localparam logic [GRAIN_W-1:0] GRAIN_DEF = 16'd20;

    // One quotient digit per level bit.
    localparam int DIV_STEPS = LEVEL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Word index of the grain register (paddr bit above the byte offset).
    localparam logic REG_GRAIN = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_GO   = 2'd1,
        ACT_SET  = 2'd2,
        ACT_STOP = 2'd3
    } t_action;

endpackage

// ===== hw/rtl/linear_ramp_generator_core.sv =====
// A go with zero duration passes from acceptance straight to EMIT; an interpolated emission
// (tick or go) passes LVL, the bit-serial multiply-divide unit, ADD, FIN and EMIT in turn,
// with LVL skipping the divider and ADD once the ramp has ended or is degenerate. One item at
// a time: items with no result leave the input ready, items with a result hold it until EMIT.
// Reset: synchronous, active low; clock, times and levels clear, grain returns to 20 ticks,
// no emission is armed and no beat is pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_ramp_generator_core
    import lrg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Item input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ACTION_W-1:0]          i_action,
    input  logic signed [LEVEL_W-1:0]    i_value,
    input  logic [RAMP_W-1:0]            i_ramp_ticks,

    // Result output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [LEVEL_W-1:0]    o_level,

    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    // The sequencer walks through these states for every item. Items that only
    // touch state (set, stop, ticks with nothing due) finish in IDLE; a go with
    // zero ramp goes straight to EMIT. Other emissions go through LVL, where the
    // interpolation is set up or skipped, the serial divider, ADD, FIN, which
    // sets the emission timer, and EMIT, which waits for a free output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LVL,
        S_DIV,
        S_ADD,
        S_FIN,
        S_EMIT
    } t_state;

    t_state                 r_state;

    // Captured item.
    t_action                r_act;
    logic [LEVEL_W-1:0]     r_val;
    logic [RAMP_W-1:0]      r_ramp;

    // Ramp state.
    logic [TIME_BITS-1:0]   r_clock;
    logic [TIME_BITS-1:0]   r_rbt;
    logic [TIME_BITS-1:0]   r_ret;
    logic [TIME_BITS-1:0]   r_next;
    logic [LEVEL_W-1:0]     r_begin;
    logic [LEVEL_W-1:0]     r_end;
    logic                   r_armed;
    logic [GRAIN_W-1:0]     r_grain;

    // Serial multiply-divide unit and its result.
    logic [LEVEL_W-1:0]     r_mag;
    logic                   r_neg;
    logic [RAMP_W-1:0]      r_el;
    logic [RAMP_W-1:0]      r_div;
    logic [RAMP_W-1:0]      r_rem;
    logic [LEVEL_W-1:0]     r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic [LEVEL_W-1:0]     r_lv;

    // Output register.
    logic                   r_out_valid;
    logic [LEVEL_W-1:0]     r_level;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;
    assign pready      = 1'b1;

    logic w_in_acc;
    logic w_cfg_wr;
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign prdata = (paddr[PADDR_W-1] == REG_GRAIN) ?
                    {{(APB_DATA_W-GRAIN_W){1'b0}}, r_grain} : '0;

    // Time arithmetic. Differences wrap modulo 2^TIME_BITS and their top bit
    // tells whether one time lies before the other.
    logic [TIME_BITS-1:0]   w_clock_inc;
    logic [TIME_BITS-1:0]   w_dur;
    logic [TIME_BITS-1:0]   w_el;
    logic [TIME_BITS-1:0]   w_gap_end;
    logic [TIME_BITS-1:0]   w_remain;
    logic [TIME_BITS-1:0]   w_grain_t;
    logic [TIME_BITS-1:0]   w_ramp_t;
    logic [TIME_BITS-1:0]   w_step;
    logic [TIME_BITS-1:0]   w_go_gap;
    logic [TIME_BITS-1:0]   w_go_step;
    logic [TIME_BITS-1:0]   w_next_gap;
    logic                   w_reached;
    logic                   w_go_reached;
    logic                   w_dur_bad;
    logic [RAMP_W-1:0]      w_el_cl;

    assign w_clock_inc  = r_clock + TIME_BITS'(1);
    assign w_dur        = r_ret - r_rbt;
    assign w_el         = r_clock - r_rbt;
    assign w_gap_end    = r_clock - r_ret;
    assign w_remain     = r_ret - r_clock;
    assign w_grain_t    = TIME_BITS'(r_grain);
    assign w_ramp_t     = TIME_BITS'(r_ramp);
    assign w_step       = (w_remain > w_grain_t) ? w_grain_t : w_remain;
    assign w_go_gap     = TIME_BITS'(0) - w_ramp_t;
    assign w_go_step    = (w_ramp_t > w_grain_t) ? w_grain_t : w_ramp_t;
    assign w_next_gap   = r_ret - r_next;
    assign w_reached    = ~w_gap_end[TIME_BITS-1];
    assign w_go_reached = ~w_go_gap[TIME_BITS-1];

    // A ramp of zero length, or one longer than the ramp field allows, holds
    // its end level. Elapsed time past the end is clamped to the duration.
    assign w_dur_bad = (w_dur == '0) || ((w_dur >> RAMP_W) != '0);
    assign w_el_cl   = (w_el > w_dur) ? w_dur[RAMP_W-1:0] : w_el[RAMP_W-1:0];

    // Magnitude and sign of the level span, which always fits in 32 bits.
    logic [LEVEL_W:0]       w_diff;
    logic [LEVEL_W:0]       w_mag_full;
    logic                   w_neg;
    assign w_diff     = {r_end[LEVEL_W-1], r_end} - {r_begin[LEVEL_W-1], r_begin};
    assign w_neg      = w_diff[LEVEL_W];
    assign w_mag_full = w_neg ? (~w_diff + (LEVEL_W+1)'(1)) : w_diff;

    // One step of the fused multiply-divide. The span magnitude enters one bit
    // per cycle, most significant first; each bit doubles the running product
    // and adds the elapsed time when set. Because the elapsed time never
    // exceeds the divisor, the partial remainder stays below three divisors,
    // so each step yields a quotient digit of 0, 1 or 2.
    logic [RAMP_W+1:0]      w_acc;
    logic [RAMP_W+1:0]      w_two;
    logic [RAMP_W+1:0]      w_one;
    logic [RAMP_W+1:0]      w_rem_nx;
    logic [1:0]             w_dig;
    logic [LEVEL_W-1:0]     w_quo_nx;
    logic [LEVEL_W-1:0]     w_sum;

    assign w_acc = {1'b0, r_rem, 1'b0} +
                   (r_mag[LEVEL_W-1] ? {2'b00, r_el} : (RAMP_W+2)'(0));
    assign w_two = {1'b0, r_div, 1'b0};
    assign w_one = {2'b00, r_div};

    always_comb begin
        priority if (w_acc >= w_two) begin
            w_rem_nx = w_acc - w_two;
            w_dig    = 2'd2;
        end else if (w_acc >= w_one) begin
            w_rem_nx = w_acc - w_one;
            w_dig    = 2'd1;
        end else begin
            w_rem_nx = w_acc;
            w_dig    = 2'd0;
        end
    end

    assign w_quo_nx = {r_quo[LEVEL_W-2:0], 1'b0} + LEVEL_W'(w_dig);

    // The quotient truncates toward zero, so the interpolated level is the
    // start level moved by it in the direction of the span.
    assign w_sum = r_neg ? (r_begin - r_quo) : (r_begin + r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock     <= '0;
            r_rbt       <= '0;
            r_ret       <= '0;
            r_next      <= '0;
            r_begin     <= '0;
            r_end       <= '0;
            r_armed     <= 1'b0;
            r_grain     <= GRAIN_DEF;
            r_out_valid <= 1'b0;
        end else begin
            // Writing zero to the grain restores the default.
            if (w_cfg_wr && (paddr[PADDR_W-1] == REG_GRAIN)) begin
                r_grain <= (pwdata[GRAIN_W-1:0] == '0) ? GRAIN_DEF : pwdata[GRAIN_W-1:0];
            end

            // In EMIT the output register is refilled below when its beat leaves.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_act  <= t_action'(i_action);
                        r_val  <= i_value;
                        r_ramp <= i_ramp_ticks;
                        unique case (t_action'(i_action))
                            ACT_TICK: begin
                                r_clock <= w_clock_inc;
                                if (r_armed && (r_next == w_clock_inc)) begin
                                    r_state <= S_LVL;
                                end
                            end
                            ACT_GO: begin
                                if (i_ramp_ticks == '0) begin
                                    // Jump: emit the target at once.
                                    r_armed <= 1'b0;
                                    r_begin <= i_value;
                                    r_end   <= i_value;
                                    r_lv    <= i_value;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_LVL;
                                end
                            end
                            ACT_SET: begin
                                r_armed <= 1'b0;
                                r_begin <= i_value;
                                r_end   <= i_value;
                            end
                            ACT_STOP: begin
                                // Freeze at the ramp's start value.
                                r_armed <= 1'b0;
                                r_end   <= r_begin;
                            end
                        endcase
                    end
                end

                S_LVL: begin
                    // Once the ramp has ended, or when it is degenerate, the
                    // level is the end level and no division is needed.
                    if (w_reached || w_dur_bad) begin
                        r_lv    <= r_end;
                        r_state <= S_FIN;
                    end else begin
                        r_mag   <= w_mag_full[LEVEL_W-1:0];
                        r_neg   <= w_neg;
                        r_el    <= w_el_cl;
                        r_div   <= w_dur[RAMP_W-1:0];
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= CNT_W'(DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_rem <= w_rem_nx[RAMP_W-1:0];
                    r_quo <= w_quo_nx;
                    r_mag <= {r_mag[LEVEL_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_ADD;
                    end
                end

                S_ADD: begin
                    r_lv    <= w_sum;
                    r_state <= S_FIN;
                end

                S_FIN: begin
                    unique case (r_act)
                        ACT_TICK: begin
                            // At the end time the exact target goes out and the
                            // timer disarms; before it, the next emission is a
                            // grain away, capped at the end time.
                            if (w_reached) begin
                                r_armed <= 1'b0;
                            end else begin
                                r_armed <= 1'b1;
                                r_next  <= r_clock + w_step;
                            end
                        end
                        ACT_GO: begin
                            // The new ramp starts at the level just found. Its
                            // first beat is that level, unless the end time wraps
                            // to a point already passed.
                            r_begin <= r_lv;
                            r_rbt   <= r_clock;
                            r_ret   <= r_clock + w_ramp_t;
                            r_end   <= r_val;
                            if (w_go_reached) begin
                                r_armed <= 1'b0;
                                r_lv    <= r_val;
                            end else begin
                                r_armed <= 1'b1;
                                r_next  <= r_clock + w_go_step;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_level     <= r_lv;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The partial remainder of the divider never reaches the divisor.
    `ASSERT_SAME(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_div, "divider remainder out of range")

    // The divider runs its full count without skipping or stalling.
    `ASSERT_NEXT(a_div_count, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt != '0), (r_state == S_DIV) && (r_cnt == $past(r_cnt) - CNT_W'(1)), "divider step count broken")

    // An armed emission never lies beyond the ramp's end time.
    `ASSERT_SAME(a_next_in_ramp, i_clk, i_rst_n, r_armed, !w_next_gap[TIME_BITS-1], "armed emission past ramp end")

endmodule
